FILE: design/twadc_pkg.sv
// ----------------------------------------------------------------------------
// twadc_pkg: shared types and constants for the two-wire ADC controller
// Opcodes, sequencer phases, register indexes, pin codes and result layout.
// ----------------------------------------------------------------------------
package twadc_pkg;

  // Field widths
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned RAW_W      = 24;
  localparam int unsigned SCALED_W   = 21;
  localparam int unsigned HALF_W     = 16;
  localparam int unsigned TIMEOUT_W  = 24;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned BITCNT_W   = 6;

  // Frame shape
  localparam logic [BITCNT_W:0] SAMPLE_BITS     = 7'd24;
  localparam logic [BITCNT_W:0] PREAMBLE_CLOCKS = 7'd29;
  localparam logic [BITCNT_W:0] CMD_BITS        = 7'd7;
  localparam logic [BITCNT_W:0] CFG_DATA_BITS   = 7'd8;
  localparam logic [BITCNT_W:0] ONE_CLOCK       = 7'd1;

  localparam logic [RAW_W-1:0] SAMPLE_MASK =
    RAW_W'((25'd1 << SAMPLE_BITS) - 25'd1);

  // Command words, sent MSB first
  localparam logic [6:0] CMD_WRITE = 7'b1100101;
  localparam logic [6:0] CMD_READ  = 7'b1010110;

  // x / 10 == (x * ceil(2^27 / 10)) >> 27 for every x below 2^26
  localparam logic [RAW_W-1:0] DIV10_RECIP = 24'hCCCCCD;
  localparam int unsigned      DIV10_SHIFT = 27;

  // Register reset values
  localparam logic [HALF_W-1:0]    HALF_PERIOD_RST     = 16'd5;
  localparam logic [HALF_W-1:0]    CMD_HALF_PERIOD_RST = 16'd30;
  localparam logic [TIMEOUT_W-1:0] CFG_TIMEOUT_RST     = 24'd750000;
  localparam logic [TIMEOUT_W-1:0] SAMPLE_TIMEOUT_RST  = 24'd1500000;

  // Pin code: bit 1 drives, bit 0 level
  localparam logic [1:0] PIN_RELEASED   = 2'b01;
  localparam logic [1:0] PIN_DRIVE_HIGH = 2'b11;
  localparam logic       PIN_DRIVE      = 1'b1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_IDLE        = 2'd0,
    OP_READ_SAMPLE = 2'd1,
    OP_WRITE_CFG   = 2'd2,
    OP_READ_CFG    = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_PERIOD     = 2'd0,
    REG_CMD_HALF_PERIOD = 2'd1,
    REG_CFG_TIMEOUT     = 2'd2,
    REG_SAMPLE_TIMEOUT  = 2'd3
  } cfg_reg_e;

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_WAIT_HIGH = 8'b0000_0010,
    PH_WAIT_LOW  = 8'b0000_0100,
    PH_PRE       = 8'b0000_1000,
    PH_CMD       = 8'b0001_0000,
    PH_TURN      = 8'b0010_0000,
    PH_DATA      = 8'b0100_0000,
    PH_CLOSE     = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic                sck;
    logic                sda_out;
    logic                sda_drive;
    logic                busy_res;
    logic                done_res;
    logic                timed_out;
    logic [RAW_W-1:0]    sample_raw;
    logic [SCALED_W-1:0] sample_scaled;
    logic [BYTE_W-1:0]   config_read;
  } out_item_t;

endpackage

FILE: design/twadc_in_if.sv
// ----------------------------------------------------------------------------
// twadc_in_if: tick channel into the two-wire ADC controller
// One transaction per timer tick: opcode, config byte and sampled data pin.
// ----------------------------------------------------------------------------
interface twadc_in_if;
  import twadc_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [BYTE_W-1:0]   config_byte;
  logic                sda_in;

  modport source (output valid, output opcode, output config_byte, output sda_in,
                  input ready);
  modport sink   (input valid, input opcode, input config_byte, input sda_in,
                  output ready);
endinterface

FILE: design/twadc_out_if.sv
// ----------------------------------------------------------------------------
// twadc_out_if: result channel out of the two-wire ADC controller
// One transaction per tick: pin levels, status flags and read-back data.
// ----------------------------------------------------------------------------
interface twadc_out_if;
  import twadc_pkg::*;

  logic                valid;
  logic                ready;
  logic                sck;
  logic                sda_out;
  logic                sda_drive;
  logic                busy_res;
  logic                done_res;
  logic                timed_out;
  logic [RAW_W-1:0]    sample_raw;
  logic [SCALED_W-1:0] sample_scaled;
  logic [BYTE_W-1:0]   config_read;

  modport source (output valid, output sck, output sda_out, output sda_drive,
                  output busy_res, output done_res, output timed_out,
                  output sample_raw, output sample_scaled, output config_read,
                  input ready);
  modport sink   (input valid, input sck, input sda_out, input sda_drive,
                  input busy_res, input done_res, input timed_out,
                  input sample_raw, input sample_scaled, input config_read,
                  output ready);
endinterface

FILE: design/two_wire_adc_serial_controller.sv
// A tick's result goes to the output register, or to the skid register on a stall.
// One tick per cycle while the skid is empty; state updates in the accepting cycle.
// An output register plus a one-entry skid register decouple the two channels.
// Reset (rst_ni, async, active low): sequencer idle, SCK low, SDA released at level
// one, both output slots empty, config registers back to their default values.
// ----------------------------------------------------------------------------
// two_wire_adc_serial_controller: tick-driven master for a two-wire ADC
// Waits for data-ready, clocks 24-bit samples in, or runs config write/read
// frames (preamble, command, turnaround, data, closing clock), with timeout.
// ----------------------------------------------------------------------------
module two_wire_adc_serial_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [twadc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [twadc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  twadc_in_if.sink                            in_i,
  twadc_out_if.source                         out_o
);
  import twadc_pkg::*;

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic [HALF_W-1:0]    half_period_q, cmd_half_period_q;
  logic [TIMEOUT_W-1:0] cfg_timeout_q, sample_timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q     <= HALF_PERIOD_RST;
      cmd_half_period_q <= CMD_HALF_PERIOD_RST;
      cfg_timeout_q     <= CFG_TIMEOUT_RST;
      sample_timeout_q  <= SAMPLE_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_HALF_PERIOD:     half_period_q     <= cfg_data_i[HALF_W-1:0];
        REG_CMD_HALF_PERIOD: cmd_half_period_q <= cfg_data_i[HALF_W-1:0];
        REG_CFG_TIMEOUT:     cfg_timeout_q     <= cfg_data_i[TIMEOUT_W-1:0];
        REG_SAMPLE_TIMEOUT:  sample_timeout_q  <= cfg_data_i[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  phase_e               phase_q, phase_d;
  op_e                  op_q, op_d;
  logic [BITCNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [HALF_W-1:0]    half_cnt_q, half_cnt_d;
  logic [TIMEOUT_W-1:0] wait_cnt_q, wait_cnt_d;
  logic [RAW_W-1:0]     shift_q, shift_d;
  logic [BYTE_W-1:0]    out_byte_q, out_byte_d;
  logic                 sck_q, sck_d;
  logic [1:0]           drive_q, drive_d;

  // Bits per segment; every other segment is a single clock
  function automatic logic [BITCNT_W:0] seg_len(phase_e ph, op_e op);
    logic [BITCNT_W:0] len;
    unique case (ph)
      PH_PRE:  len = PREAMBLE_CLOCKS;
      PH_CMD:  len = CMD_BITS;
      PH_DATA: len = (op == OP_READ_SAMPLE) ? SAMPLE_BITS : CFG_DATA_BITS;
      default: len = ONE_CLOCK;
    endcase
    return len;
  endfunction

  // Config frame order
  function automatic phase_e next_seg(phase_e ph);
    phase_e nxt;
    unique case (ph)
      PH_PRE:  nxt = PH_CMD;
      PH_CMD:  nxt = PH_TURN;
      PH_TURN: nxt = PH_DATA;
      default: nxt = PH_CLOSE;
    endcase
    return nxt;
  endfunction

  // Data pin for the bit about to be clocked out
  function automatic logic [1:0] pins(phase_e ph, op_e op, logic [BITCNT_W-1:0] bc,
                                      logic [BYTE_W-1:0] ob, logic [1:0] cur);
    logic [6:0] cmd;
    logic [2:0] cmd_idx;
    logic [1:0] p;
    cmd     = (op == OP_WRITE_CFG) ? CMD_WRITE : CMD_READ;
    cmd_idx = 3'd6 - bc[2:0];
    unique case (ph)
      PH_PRE:   p = (op == OP_WRITE_CFG) ? PIN_RELEASED : PIN_DRIVE_HIGH;
      PH_CMD:   p = {PIN_DRIVE, cmd[cmd_idx]};
      PH_TURN:  p = PIN_DRIVE_HIGH;
      PH_DATA:  p = (op == OP_WRITE_CFG) ? {PIN_DRIVE, ob[~bc[2:0]]} : PIN_RELEASED;
      PH_CLOSE: p = (op == OP_WRITE_CFG) ? {PIN_DRIVE, ob[0]} : PIN_RELEASED;
      default:  p = cur;
    endcase
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Handshake and output slots
  // --------------------------------------------------------------------------
  out_item_t out_q, skid_q, res;
  logic      out_vld_q, skid_vld_q;
  logic      accept, out_free;

  assign in_i.ready = !skid_vld_q;
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;

  // --------------------------------------------------------------------------
  // Next-state logic for one tick
  // --------------------------------------------------------------------------
  logic [TIMEOUT_W-1:0] limit, wait_inc;
  logic [HALF_W-1:0]    hp;
  logic [HALF_W:0]      half_inc;
  logic [BITCNT_W:0]    bit_inc;
  logic                 fin, res_done, res_tmo;
  phase_e               seg_nxt;
  logic [2*RAW_W-1:0]   prod;
  logic [RAW_W-1:0]     raw;

  always_comb begin
    phase_d    = phase_q;
    op_d       = op_q;
    bit_cnt_d  = bit_cnt_q;
    half_cnt_d = half_cnt_q;
    wait_cnt_d = wait_cnt_q;
    shift_d    = shift_q;
    out_byte_d = out_byte_q;
    sck_d      = sck_q;
    drive_d    = drive_q;
    fin        = 1'b0;
    res_done   = 1'b0;
    res_tmo    = 1'b0;

    // A zero limit behaves as one
    limit = (op_q == OP_READ_SAMPLE) ? sample_timeout_q : cfg_timeout_q;
    if (limit == '0) begin
      limit = TIMEOUT_W'(1);
    end
    wait_inc = wait_cnt_q + TIMEOUT_W'(1);
    // A zero half period needs no fix-up: the incremented count is always >= 0
    hp       = (phase_q == PH_CMD) ? cmd_half_period_q : half_period_q;
    half_inc = {1'b0, half_cnt_q} + (HALF_W+1)'(1);
    bit_inc  = {1'b0, bit_cnt_q} + (BITCNT_W+1)'(1);
    seg_nxt  = (op_q == OP_READ_SAMPLE) ? PH_DATA : PH_PRE;

    if (accept) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (op_e'(in_i.opcode) != OP_IDLE) begin
            op_d       = op_e'(in_i.opcode);
            wait_cnt_d = '0;
            shift_d    = '0;
            out_byte_d = (op_e'(in_i.opcode) == OP_WRITE_CFG) ? in_i.config_byte : '0;
            bit_cnt_d  = '0;
            half_cnt_d = '0;
            sck_d      = 1'b0;
            drive_d    = PIN_RELEASED;
            phase_d    = (op_e'(in_i.opcode) == OP_READ_SAMPLE) ? PH_WAIT_HIGH : PH_WAIT_LOW;
          end
        end
        PH_WAIT_HIGH, PH_WAIT_LOW: begin
          if (phase_q == PH_WAIT_HIGH && in_i.sda_in) begin
            phase_d = PH_WAIT_LOW;
          end else if (phase_q == PH_WAIT_LOW && !in_i.sda_in) begin
            phase_d    = seg_nxt;
            bit_cnt_d  = '0;
            half_cnt_d = '0;
            sck_d      = 1'b1;
            drive_d    = pins(seg_nxt, op_q, '0, out_byte_q, drive_q);
          end else begin
            wait_cnt_d = wait_inc;
            if (wait_inc >= limit) begin
              phase_d  = PH_IDLE;
              sck_d    = 1'b1;
              drive_d  = PIN_DRIVE_HIGH;
              res_done = 1'b1;
              res_tmo  = 1'b1;
            end
          end
        end
        default: begin
          half_cnt_d = half_inc[HALF_W-1:0];
          if (half_inc >= {1'b0, hp}) begin
            half_cnt_d = '0;
            if (sck_q) begin
              // End of high half: sample bits are taken here
              if (op_q == OP_READ_SAMPLE && phase_q == PH_DATA) begin
                shift_d = {shift_q[RAW_W-2:0], in_i.sda_in};
              end
              sck_d = 1'b0;
            end else begin
              // End of low half: config read bits are taken here
              if (op_q == OP_READ_CFG && phase_q == PH_DATA) begin
                shift_d = {shift_q[RAW_W-2:0], in_i.sda_in};
              end
              bit_cnt_d = bit_inc[BITCNT_W-1:0];
              if (bit_inc < seg_len(phase_q, op_q)) begin
                sck_d   = 1'b1;
                drive_d = pins(phase_q, op_q, bit_inc[BITCNT_W-1:0], out_byte_q, drive_q);
              end else if (op_q == OP_READ_SAMPLE || phase_q == PH_CLOSE) begin
                fin = 1'b1;
              end else begin
                phase_d    = next_seg(phase_q);
                bit_cnt_d  = '0;
                half_cnt_d = '0;
                sck_d      = 1'b1;
                drive_d    = pins(next_seg(phase_q), op_q, '0, out_byte_q, drive_q);
              end
            end
          end
        end
      endcase
    end

    if (fin) begin
      phase_d  = PH_IDLE;
      sck_d    = 1'b0;
      drive_d  = PIN_DRIVE_HIGH;
      res_done = 1'b1;
    end
  end

  // Shift register is unchanged on the finishing tick, so read it directly
  assign raw  = (fin && op_q == OP_READ_SAMPLE) ? (shift_q & SAMPLE_MASK) : '0;
  assign prod = raw * DIV10_RECIP;

  always_comb begin
    res.sck           = sck_d;
    res.sda_out       = drive_d[0];
    res.sda_drive     = drive_d[1];
    res.busy_res      = (phase_d != PH_IDLE);
    res.done_res      = res_done;
    res.timed_out     = res_tmo;
    res.sample_raw    = raw;
    res.sample_scaled = prod[DIV10_SHIFT +: SCALED_W];
    res.config_read   = (fin && op_q == OP_READ_CFG) ? shift_q[BYTE_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      op_q       <= OP_IDLE;
      bit_cnt_q  <= '0;
      half_cnt_q <= '0;
      wait_cnt_q <= '0;
      shift_q    <= '0;
      out_byte_q <= '0;
      sck_q      <= 1'b0;
      drive_q    <= PIN_RELEASED;
    end else begin
      phase_q    <= phase_d;
      op_q       <= op_d;
      bit_cnt_q  <= bit_cnt_d;
      half_cnt_q <= half_cnt_d;
      wait_cnt_q <= wait_cnt_d;
      shift_q    <= shift_d;
      out_byte_q <= out_byte_d;
      sck_q      <= sck_d;
      drive_q    <= drive_d;
    end
  end

  // Output register with one skid entry; skid only fills when the output stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q  <= skid_vld_q || accept;
      skid_vld_q <= 1'b0;
    end else if (accept) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.sck           = out_q.sck;
  assign out_o.sda_out       = out_q.sda_out;
  assign out_o.sda_drive     = out_q.sda_drive;
  assign out_o.busy_res      = out_q.busy_res;
  assign out_o.done_res      = out_q.done_res;
  assign out_o.timed_out     = out_q.timed_out;
  assign out_o.sample_raw    = out_q.sample_raw;
  assign out_o.sample_scaled = out_q.sample_scaled;
  assign out_o.config_read   = out_q.config_read;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held while output slot empty");

  a_timeout_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res.timed_out) |-> res.done_res)
    else $error("timeout reported without done");

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res.done_res) |=> (phase_q == PH_IDLE))
    else $error("sequencer not idle after done");

  a_cmd_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CMD) |-> (bit_cnt_q < BITCNT_W'(CMD_BITS)))
    else $error("command bit count out of range");

  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_q == PH_IDLE) |-> !res.done_res)
    else $error("done raised on a start or idle tick");

endmodule

FILE: bench/tb_two_wire_adc_serial_controller.sv
// ----------------------------------------------------------------------------
// tb_two_wire_adc_serial_controller: self-checking bench for the ADC master
// Feeds timer ticks with ADC-like data-pin behaviour, tracks the expected pin
// state and read-back per tick, and compares every result transaction with it.
// ----------------------------------------------------------------------------
module tb_two_wire_adc_serial_controller;
  import twadc_pkg::*;

  localparam int unsigned OP_TICKS   = 40;    // ticks of operations per random phase
  localparam int unsigned END_GUARD  = 2000;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_e;

  // Tracks the controller sequencer and holds the pin states still to come.
  class adc_pin_tracker;
    logic [HALF_W-1:0]    half_ticks, cmd_half_ticks;
    logic [TIMEOUT_W-1:0] cfg_limit, smp_limit;
    phase_e               seq_phase;
    op_e                  cur_op;
    int unsigned          bit_cnt, half_cnt;
    logic [TIMEOUT_W-1:0] wait_cnt;
    logic [RAW_W-1:0]     shreg;
    logic [BYTE_W-1:0]    tx_byte;
    logic                 sck_lvl;
    logic [1:0]           pin;
    out_item_t            expected_pins[$];
    int unsigned          mismatches;

    function new();
      half_ticks     = HALF_PERIOD_RST;
      cmd_half_ticks = CMD_HALF_PERIOD_RST;
      cfg_limit      = CFG_TIMEOUT_RST;
      smp_limit      = SAMPLE_TIMEOUT_RST;
      seq_phase      = PH_IDLE;
      cur_op         = OP_IDLE;
      bit_cnt        = 0;
      half_cnt       = 0;
      wait_cnt       = '0;
      shreg          = '0;
      tx_byte        = '0;
      sck_lvl        = 1'b0;
      pin            = PIN_RELEASED;
      mismatches     = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_HALF_PERIOD:     half_ticks     = v[HALF_W-1:0];
        REG_CMD_HALF_PERIOD: cmd_half_ticks = v[HALF_W-1:0];
        REG_CFG_TIMEOUT:     cfg_limit      = v[TIMEOUT_W-1:0];
        REG_SAMPLE_TIMEOUT:  smp_limit      = v[TIMEOUT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned seg_len();
      case (seq_phase)
        PH_PRE:  return 32'(PREAMBLE_CLOCKS);
        PH_CMD:  return 32'(CMD_BITS);
        PH_DATA: return (cur_op == OP_READ_SAMPLE) ? 32'(SAMPLE_BITS) : 32'(CFG_DATA_BITS);
        default: return 32'(ONE_CLOCK);
      endcase
    endfunction

    // Data-pin drive for the bit now starting
    function void drive_pin();
      logic [6:0] cmd;
      cmd = (cur_op == OP_WRITE_CFG) ? CMD_WRITE : CMD_READ;
      case (seq_phase)
        PH_PRE:  pin = (cur_op == OP_WRITE_CFG) ? PIN_RELEASED : PIN_DRIVE_HIGH;
        PH_CMD:  pin = {PIN_DRIVE, cmd[3'(6 - (bit_cnt % 7))]};
        PH_TURN: pin = PIN_DRIVE_HIGH;
        PH_DATA: pin = (cur_op == OP_WRITE_CFG) ? {PIN_DRIVE, tx_byte[3'(7 - (bit_cnt & 7))]}
                                                : PIN_RELEASED;
        PH_CLOSE: pin = (cur_op == OP_WRITE_CFG) ? {PIN_DRIVE, tx_byte[0]} : PIN_RELEASED;
        default: ;
      endcase
    endfunction

    function void enter(phase_e p);
      seq_phase = p;
      bit_cnt   = 0;
      half_cnt  = 0;
      sck_lvl   = 1'b1;
      drive_pin();
    endfunction

    // One accepted tick: advance the sequencer and queue the pin state it gives
    function void note_tick(op_e op, logic [BYTE_W-1:0] cb, logic sda);
      out_item_t         pins;
      logic [TIMEOUT_W-1:0] lim;
      logic [HALF_W-1:0] h;
      phase_e            nxt;
      bit                finish;
      pins   = '0;
      finish = 1'b0;
      case (seq_phase)
        PH_IDLE: begin
          if (op != OP_IDLE) begin
            cur_op    = op;
            wait_cnt  = '0;
            shreg     = '0;
            tx_byte   = (op == OP_WRITE_CFG) ? cb : '0;
            bit_cnt   = 0;
            half_cnt  = 0;
            sck_lvl   = 1'b0;
            pin       = PIN_RELEASED;
            seq_phase = (op == OP_READ_SAMPLE) ? PH_WAIT_HIGH : PH_WAIT_LOW;
          end
        end
        PH_WAIT_HIGH, PH_WAIT_LOW: begin
          lim = (cur_op == OP_READ_SAMPLE) ? smp_limit : cfg_limit;
          if (lim == '0) lim = TIMEOUT_W'(1);
          if (seq_phase == PH_WAIT_HIGH && sda) begin
            seq_phase = PH_WAIT_LOW;
          end else if (seq_phase == PH_WAIT_LOW && !sda) begin
            enter((cur_op == OP_READ_SAMPLE) ? PH_DATA : PH_PRE);
          end else begin
            wait_cnt = wait_cnt + 1'b1;
            if (wait_cnt >= lim) begin
              seq_phase      = PH_IDLE;
              sck_lvl        = 1'b1;
              pin            = PIN_DRIVE_HIGH;
              pins.done_res  = 1'b1;
              pins.timed_out = 1'b1;
            end
          end
        end
        default: begin
          h = (seq_phase == PH_CMD) ? cmd_half_ticks : half_ticks;
          if (h == '0) h = HALF_W'(1);
          half_cnt++;
          if (half_cnt >= h) begin
            half_cnt = 0;
            if (sck_lvl) begin
              // sample bits are taken at the end of the high half
              if (cur_op == OP_READ_SAMPLE && seq_phase == PH_DATA) shreg = {shreg[RAW_W-2:0], sda};
              sck_lvl = 1'b0;
            end else begin
              // config read bits at the end of the low half
              if (cur_op == OP_READ_CFG && seq_phase == PH_DATA) shreg = {shreg[RAW_W-2:0], sda};
              bit_cnt++;
              if (bit_cnt < seg_len()) begin
                sck_lvl = 1'b1;
                drive_pin();
              end else if (cur_op == OP_READ_SAMPLE || seq_phase == PH_CLOSE) begin
                finish = 1'b1;
              end else begin
                case (seq_phase)
                  PH_PRE:  nxt = PH_CMD;
                  PH_CMD:  nxt = PH_TURN;
                  PH_TURN: nxt = PH_DATA;
                  default: nxt = PH_CLOSE;
                endcase
                enter(nxt);
              end
            end
          end
        end
      endcase

      if (finish) begin
        seq_phase     = PH_IDLE;
        sck_lvl       = 1'b0;
        pin           = PIN_DRIVE_HIGH;
        pins.done_res = 1'b1;
        if (cur_op == OP_READ_SAMPLE) begin
          pins.sample_raw    = shreg & SAMPLE_MASK;
          pins.sample_scaled = SCALED_W'((shreg & SAMPLE_MASK) / 24'd10);
        end else if (cur_op == OP_READ_CFG) begin
          pins.config_read = shreg[BYTE_W-1:0];
        end
      end

      pins.sck       = sck_lvl;
      pins.sda_out   = pin[0];
      pins.sda_drive = pin[1];
      pins.busy_res  = (seq_phase != PH_IDLE);
      expected_pins.push_back(pins);
    endfunction

    task report_mismatch(string what, logic [RAW_W-1:0] got, logic [RAW_W-1:0] want);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
      mismatches++;
    endtask

    task check_pins(out_item_t got);
      out_item_t want;
      if (expected_pins.size() == 0) begin
        report_mismatch("unexpected transaction", '0, '0);
        return;
      end
      want = expected_pins.pop_front();
      if (got.sck !== want.sck)
        report_mismatch("sck", RAW_W'(got.sck), RAW_W'(want.sck));
      if (got.sda_out !== want.sda_out)
        report_mismatch("sda_out", RAW_W'(got.sda_out), RAW_W'(want.sda_out));
      if (got.sda_drive !== want.sda_drive)
        report_mismatch("sda_drive", RAW_W'(got.sda_drive), RAW_W'(want.sda_drive));
      if (got.busy_res !== want.busy_res)
        report_mismatch("busy_res", RAW_W'(got.busy_res), RAW_W'(want.busy_res));
      if (got.done_res !== want.done_res)
        report_mismatch("done_res", RAW_W'(got.done_res), RAW_W'(want.done_res));
      if (got.timed_out !== want.timed_out)
        report_mismatch("timed_out", RAW_W'(got.timed_out), RAW_W'(want.timed_out));
      if (got.sample_raw !== want.sample_raw)
        report_mismatch("sample_raw", got.sample_raw, want.sample_raw);
      if (got.sample_scaled !== want.sample_scaled)
        report_mismatch("sample_scaled", RAW_W'(got.sample_scaled),
                        RAW_W'(want.sample_scaled));
      if (got.config_read !== want.config_read)
        report_mismatch("config_read", RAW_W'(got.config_read), RAW_W'(want.config_read));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  twadc_in_if  in_if ();
  twadc_out_if out_if ();

  adc_pin_tracker sb;
  int unsigned    gap_pct;     // chance of an idle cycle before each tick
  int unsigned    stall_pct;   // chance of holding off the result channel
  int unsigned    op_ticks;

  two_wire_adc_serial_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: check on each accepted transaction, then pick the next ready level
  initial begin
    out_item_t got;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got.sck           = out_if.sck;
        got.sda_out       = out_if.sda_out;
        got.sda_drive     = out_if.sda_drive;
        got.busy_res      = out_if.busy_res;
        got.done_res      = out_if.done_res;
        got.timed_out     = out_if.timed_out;
        got.sample_raw    = out_if.sample_raw;
        got.sample_scaled = out_if.sample_scaled;
        got.config_read   = out_if.config_read;
        sb.check_pins(got);
      end
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offer one tick and hold it until the block takes it
  task automatic send_tick(op_e op, logic [BYTE_W-1:0] cb, logic sda);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= op;
    in_if.config_byte <= cb;
    in_if.sda_in      <= sda;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_tick(op, cb, sda);
  endtask

  // One operation from its start tick to the tick that leaves the block idle.
  // The data pin acts as the ADC would: not ready for a number of ticks, then
  // ready; a stuck converter never signals ready, a noisy pin is pure chance.
  task automatic run_transfer(op_e op, logic [BYTE_W-1:0] cb, int hi_lag, int lo_lag,
                              bit stuck, bit pass_high, fill_e fill, bit noisy);
    int   n_hi;
    int   n_lo;
    logic s;
    n_hi = 0;
    n_lo = 0;
    send_tick(op, cb, 1'($urandom));
    op_ticks++;
    while (sb.seq_phase != PH_IDLE) begin
      case (sb.seq_phase)
        PH_WAIT_HIGH: begin
          s = noisy ? 1'($urandom) : !((stuck && !pass_high) || n_hi < hi_lag);
          n_hi++;
        end
        PH_WAIT_LOW: begin
          s = noisy ? 1'($urandom) : (stuck || n_lo < lo_lag);
          n_lo++;
        end
        default: begin
          case (fill)
            FILL_ONES:  s = 1'b1;
            FILL_ZEROS: s = 1'b0;
            default:    s = 1'($urandom);
          endcase
        end
      endcase
      // opcodes offered while busy must be ignored
      send_tick(op_e'($urandom_range(0, 3)), 8'($urandom), s);
      op_ticks++;
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected_pins.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic load_settings(logic [HALF_W-1:0] h, logic [HALF_W-1:0] c,
                               logic [TIMEOUT_W-1:0] ct, logic [TIMEOUT_W-1:0] st);
    write_reg(REG_HALF_PERIOD, CFG_DATA_W'(h));
    write_reg(REG_CMD_HALF_PERIOD, CFG_DATA_W'(c));
    write_reg(REG_CFG_TIMEOUT, ct);
    write_reg(REG_SAMPLE_TIMEOUT, st);
    cfg_we_i <= 1'b0;
  endtask

  // Random operations with short clocks and short ready limits, so that timeouts
  // land on both sides of the limit and every frame runs to its end
  task automatic run_phase(int unsigned gap, int unsigned stall);
    int kind;
    gap_pct   = gap;
    stall_pct = stall;
    load_settings(HALF_W'($urandom_range(1, 2)), HALF_W'($urandom_range(1, 2)),
                  TIMEOUT_W'($urandom_range(1, 12)), TIMEOUT_W'($urandom_range(1, 12)));
    op_ticks = 0;
    while (op_ticks < OP_TICKS) begin
      repeat ($urandom_range(0, 2)) send_tick(OP_IDLE, 8'($urandom), 1'($urandom));
      kind = $urandom_range(0, 9);
      run_transfer(op_e'($urandom_range(1, 3)), 8'($urandom),
                   $urandom_range(0, 5), $urandom_range(0, 5),
                   kind == 0, 1'($urandom), ($urandom_range(0, 9) == 0) ?
                   fill_e'($urandom_range(1, 2)) : FILL_RANDOM, kind == 1);
    end
    drain();
  endtask

  initial begin
    int unsigned guard;
    sb = new();
    gap_pct   = 0;
    stall_pct = 0;
    rst_ni    = 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= REG_HALF_PERIOD;
    cfg_data_i        <= '0;
    in_if.valid       <= 1'b0;
    in_if.opcode      <= OP_IDLE;
    in_if.config_byte <= '0;
    in_if.sda_in      <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults after reset: idle ticks and one full-scale sample
    send_tick(OP_IDLE, 8'hFF, 1'b1);
    send_tick(OP_IDLE, 8'h00, 1'b0);
    run_transfer(OP_READ_SAMPLE, 8'h00, 2, 1, 1'b0, 1'b0, FILL_ONES, 1'b0);
    drain();

    // Fastest clocks, longest limits: write, read back and a noisy sample
    load_settings(16'd1, 16'd1, 24'hFFFFFF, 24'hFFFFFF);
    run_transfer(OP_WRITE_CFG, 8'hFF, 1, 0, 1'b0, 1'b0, FILL_RANDOM, 1'b0);
    run_transfer(OP_READ_CFG, 8'hFF, 0, 1, 1'b0, 1'b0, FILL_ONES, 1'b0);
    run_transfer(OP_READ_SAMPLE, 8'hFF, 0, 0, 1'b0, 1'b0, FILL_RANDOM, 1'b1);
    drain();

    // Slowest clocks, shortest limits: a converter that never signals ready
    load_settings(16'hFFFF, 16'hFFFF, 24'd1, 24'd1);
    run_transfer(OP_READ_SAMPLE, 8'h00, 0, 0, 1'b1, 1'b0, FILL_RANDOM, 1'b0);
    run_transfer(OP_READ_SAMPLE, 8'h00, 0, 0, 1'b1, 1'b1, FILL_RANDOM, 1'b0);
    run_transfer(OP_WRITE_CFG, 8'hC3, 0, 0, 1'b1, 1'b0, FILL_RANDOM, 1'b0);
    run_transfer(OP_READ_CFG, 8'h3C, 0, 0, 1'b1, 1'b0, FILL_RANDOM, 1'b0);
    drain();

    // Random part under each flow-control pattern
    run_phase(0, 0);
    run_phase(51, 0);
    run_phase(0, 51);
    run_phase(17, 17);

    guard = 0;
    while (sb.expected_pins.size() != 0 && guard < END_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    if (sb.expected_pins.size() != 0)
      sb.report_mismatch("missing transactions", RAW_W'(sb.expected_pins.size()), '0);
    repeat (8) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
design/twadc_pkg.sv
design/twadc_in_if.sv
design/twadc_out_if.sv
design/two_wire_adc_serial_controller.sv
bench/tb_two_wire_adc_serial_controller.sv
